// ===== rtl/ssiw_pkg.sv =====
package ssiw_pkg;

  localparam int BYTE_W     = 8;
  localparam int PATTERN_W  = 64;
  localparam int LENGTH_W   = 4;
  localparam int TIMEOUT_W  = 32;
  localparam int FUNC_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  localparam int MAX_SENTINEL_DEF = 8;
  localparam int COUNT_WIDTH_DEF  = 32;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 32'd5000;

  localparam logic [FUNC_W-1:0] FUNC_BYTE  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

  localparam logic REASON_SENTINEL = 1'b0;
  localparam logic REASON_IDLE     = 1'b1;

  typedef struct packed {
    logic shift;
    logic clear;
  } win_ctl_t;

endpackage

// ===== rtl/ssiw_in_if.sv =====
interface ssiw_in_if;
  logic                              valid;
  logic                              ready;
  logic [ssiw_pkg::FUNC_W-1:0]       func;
  logic [ssiw_pkg::BYTE_W-1:0]       data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

// ===== rtl/ssiw_out_if.sv =====
interface ssiw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        echo_valid;
  logic [ssiw_pkg::BYTE_W-1:0] echo_byte;
  logic                        monitoring_on;
  logic                        quit_now;
  logic                        quit_reason;

  modport source (output valid, output echo_valid, output echo_byte, output monitoring_on,
                  output quit_now, output quit_reason, input ready);
  modport sink   (input valid, input echo_valid, input echo_byte, input monitoring_on,
                  input quit_now, input quit_reason, output ready);
endinterface

// ===== rtl/ssiw_cell.sv =====
module ssiw_cell #(
  parameter int IDX = 0
) (
  input  logic                              clk,
  input  logic                              shift,
  input  logic [ssiw_pkg::BYTE_W-1:0]       byte_in,
  input  logic [ssiw_pkg::PATTERN_W-1:0]    pattern,
  input  logic [ssiw_pkg::LENGTH_W-1:0]     len_eff,
  input  logic                              match_in,
  output logic [ssiw_pkg::BYTE_W-1:0]       byte_out,
  output logic                              match_out
);

  logic [ssiw_pkg::BYTE_W-1:0]   byte_r;
  logic [ssiw_pkg::LENGTH_W-1:0] want_idx;
  logic [ssiw_pkg::BYTE_W-1:0]   want;
  logic                          in_use;

  // Cell IDX holds the byte received IDX bytes ago; it must equal sentinel
  // byte len-1-IDX once the incoming byte has been shifted in.
  assign in_use   = ssiw_pkg::LENGTH_W'(IDX) < len_eff;
  assign want_idx = len_eff - ssiw_pkg::LENGTH_W'(IDX + 1);
  assign want     = pattern[{want_idx[2:0], 3'b000} +: ssiw_pkg::BYTE_W];

  assign match_out = match_in && (!in_use || (byte_in == want));
  assign byte_out  = byte_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      byte_r <= byte_in;
    end
  end

endmodule

// ===== rtl/ssiw_window.sv =====
module ssiw_window #(
  parameter int MAX_SENTINEL = ssiw_pkg::MAX_SENTINEL_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ssiw_pkg::win_ctl_t             ctl,
  input  logic [ssiw_pkg::BYTE_W-1:0]    byte_in,
  input  logic [ssiw_pkg::PATTERN_W-1:0] pattern,
  input  logic [ssiw_pkg::LENGTH_W-1:0]  len_eff,
  output logic                           hit
);

  localparam int FILL_W = $clog2(MAX_SENTINEL + 1);

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;

  logic [ssiw_pkg::BYTE_W-1:0] chain_byte [MAX_SENTINEL+1];
  logic                        chain_match [MAX_SENTINEL+1];

  assign chain_byte[0]  = byte_in;
  assign chain_match[0] = 1'b1;

  for (genvar i = 0; i < MAX_SENTINEL; i++) begin : g_cell
    ssiw_cell #(.IDX(i)) u_cell (
      .clk       (clk),
      .shift     (ctl.shift),
      .byte_in   (chain_byte[i]),
      .pattern   (pattern),
      .len_eff   (len_eff),
      .match_in  (chain_match[i]),
      .byte_out  (chain_byte[i+1]),
      .match_out (chain_match[i+1])
    );
  end

  always_comb begin
    fill_nxt = fill_r;
    if (ctl.clear) begin
      fill_nxt = '0;
    end else if (ctl.shift && (fill_r < FILL_W'(MAX_SENTINEL))) begin
      fill_nxt = fill_r + 1'b1;
    end
  end

  assign hit = ctl.shift && !ctl.clear && (len_eff != '0) &&
               (ssiw_pkg::LENGTH_W'(fill_nxt) >= len_eff) && chain_match[MAX_SENTINEL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== rtl/serial_sentinel_idle_watch.sv =====
// Serial sentinel and idle watch. Each input transaction (a received byte, a
// tick, or a start) yields exactly one result transaction in the next cycle,
// and a new transaction is accepted every cycle unless the result register is
// full and the sink holds ready low. The sentinel window is a row of byte
// cells that shift on every monitored byte while no quit is pending; each
// cell compares its incoming byte with its sentinel byte and passes the
// running match to the next cell. The idle counter is COUNT_WIDTH bits wide
// and saturates. Configuration writes must be made while no transaction is
// outstanding; writing the sentinel pattern or length empties the window.
module serial_sentinel_idle_watch #(
  parameter int MAX_SENTINEL = ssiw_pkg::MAX_SENTINEL_DEF,
  parameter int COUNT_WIDTH  = ssiw_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ssiw_in_if.sink                         in_ch,
  ssiw_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [ssiw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssiw_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CMP_W = (COUNT_WIDTH > ssiw_pkg::TIMEOUT_W) ? COUNT_WIDTH
                                                              : ssiw_pkg::TIMEOUT_W;

  logic [ssiw_pkg::PATTERN_W-1:0] pattern_r;
  logic [ssiw_pkg::LENGTH_W-1:0]  length_r;
  logic [ssiw_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [ssiw_pkg::LENGTH_W-1:0]  len_eff;

  logic [COUNT_WIDTH-1:0] count_r, count_nxt, count_inc;
  logic                   started_r, started_nxt;
  logic                   mon_r, mon_nxt;
  logic                   pend_r, pend_nxt;
  logic                   reason_r, reason_nxt;

  logic                          out_valid_r;
  logic                          echo_valid_r, echo_valid_nxt;
  logic [ssiw_pkg::BYTE_W-1:0]   echo_byte_r, echo_byte_nxt;
  logic                          quit_now_r, quit_now_nxt;
  logic                          quit_reason_r, quit_reason_nxt;

  logic               accept;
  logic               timeout_hit;
  logic               win_hit;
  ssiw_pkg::win_ctl_t win_ctl;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  assign len_eff = (length_r > ssiw_pkg::LENGTH_W'(MAX_SENTINEL))
                   ? ssiw_pkg::LENGTH_W'(MAX_SENTINEL) : length_r;

  assign count_inc   = (started_r && (count_r != '1)) ? count_r + 1'b1 : count_r;
  assign timeout_hit = CMP_W'(count_inc) >= CMP_W'(timeout_r);

  assign win_ctl.clear = cfg_we && ((cfg_index == ssiw_pkg::REG_PATTERN) ||
                                    (cfg_index == ssiw_pkg::REG_LENGTH));
  assign win_ctl.shift = accept && (in_ch.func == ssiw_pkg::FUNC_BYTE) &&
                         mon_r && !pend_r && (len_eff != '0);

  ssiw_window #(.MAX_SENTINEL(MAX_SENTINEL)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (win_ctl),
    .byte_in (in_ch.data_byte),
    .pattern (pattern_r),
    .len_eff (len_eff),
    .hit     (win_hit)
  );

  always_comb begin
    count_nxt       = count_r;
    started_nxt     = started_r;
    mon_nxt         = mon_r;
    pend_nxt        = pend_r;
    reason_nxt      = reason_r;
    echo_valid_nxt  = 1'b0;
    echo_byte_nxt   = '0;
    quit_now_nxt    = 1'b0;
    quit_reason_nxt = 1'b0;
    unique case (in_ch.func)
      ssiw_pkg::FUNC_BYTE: begin
        echo_valid_nxt = 1'b1;
        echo_byte_nxt  = in_ch.data_byte;
        if (mon_r && !pend_r) begin
          count_nxt = '0;
          if (win_hit) begin
            pend_nxt   = 1'b1;
            reason_nxt = ssiw_pkg::REASON_SENTINEL;
          end
        end
      end
      ssiw_pkg::FUNC_TICK: begin
        count_nxt = count_inc;
        if (mon_r) begin
          if (!pend_r && started_r && timeout_hit) begin
            pend_nxt   = 1'b1;
            reason_nxt = ssiw_pkg::REASON_IDLE;
          end
          if (pend_nxt) begin
            mon_nxt         = 1'b0;
            quit_now_nxt    = 1'b1;
            quit_reason_nxt = reason_nxt;
          end
        end
      end
      ssiw_pkg::FUNC_START: begin
        mon_nxt     = 1'b1;
        pend_nxt    = 1'b0;
        count_nxt   = '0;
        started_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      length_r  <= '0;
      timeout_r <= ssiw_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssiw_pkg::REG_PATTERN: pattern_r <= cfg_data;
        ssiw_pkg::REG_LENGTH:  length_r  <= cfg_data[ssiw_pkg::LENGTH_W-1:0];
        ssiw_pkg::REG_TIMEOUT: timeout_r <= cfg_data[ssiw_pkg::TIMEOUT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      started_r   <= 1'b0;
      mon_r       <= 1'b0;
      pend_r      <= 1'b0;
      reason_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r   <= count_nxt;
        started_r <= started_nxt;
        mon_r     <= mon_nxt;
        pend_r    <= pend_nxt;
        reason_r  <= reason_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      echo_valid_r  <= echo_valid_nxt;
      echo_byte_r   <= echo_byte_nxt;
      quit_now_r    <= quit_now_nxt;
      quit_reason_r <= quit_reason_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.echo_valid    = echo_valid_r;
  assign out_ch.echo_byte     = echo_byte_r;
  assign out_ch.monitoring_on = mon_r;
  assign out_ch.quit_now      = quit_now_r;
  assign out_ch.quit_reason   = quit_reason_r;

endmodule
